// ----- hw/rtl/jts_pkg.sv -----
`timescale 1ns / 1ps

package jts_pkg;

    typedef enum logic [4:0] {
        M_START  = 5'd0,
        M_ERROR  = 5'd1,
        M_LIT    = 5'd2,
        M_STR    = 5'd3,
        M_ESC    = 5'd4,
        M_HEX1   = 5'd5,
        M_BSL    = 5'd6,
        M_U      = 5'd7,
        M_HEX2   = 5'd8,
        M_UTF8   = 5'd9,
        M_NMINUS = 5'd10,
        M_NZERO  = 5'd11,
        M_NINT   = 5'd12,
        M_NPOINT = 5'd13,
        M_NFRAC  = 5'd14,
        M_NEXP   = 5'd15,
        M_NSIGN  = 5'd16,
        M_NEXPD  = 5'd17
    } scan_mode_t;

    localparam logic [3:0] EV_STR_BYTE = 4'd0;
    localparam logic [3:0] EV_STR_END  = 4'd1;
    localparam logic [3:0] EV_NUM_BYTE = 4'd2;
    localparam logic [3:0] EV_NUM_END  = 4'd3;
    localparam logic [3:0] EV_LBRACK   = 4'd4;
    localparam logic [3:0] EV_RBRACK   = 4'd5;
    localparam logic [3:0] EV_LBRACE   = 4'd6;
    localparam logic [3:0] EV_RBRACE   = 4'd7;
    localparam logic [3:0] EV_COLON    = 4'd8;
    localparam logic [3:0] EV_COMMA    = 4'd9;
    localparam logic [3:0] EV_TRUE     = 4'd10;
    localparam logic [3:0] EV_END      = 4'd13;
    localparam logic [3:0] EV_ERROR    = 4'd14;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_UNCLOSED = 4'd1;
    localparam logic [3:0] ERR_CONTROL  = 4'd2;
    localparam logic [3:0] ERR_ESCAPE   = 4'd3;
    localparam logic [3:0] ERR_HEX      = 4'd4;
    localparam logic [3:0] ERR_NO_LOW   = 4'd5;
    localparam logic [3:0] ERR_LONE_LOW = 4'd6;
    localparam logic [3:0] ERR_UTF8     = 4'd7;
    localparam logic [3:0] ERR_MINUS    = 4'd8;
    localparam logic [3:0] ERR_POINT    = 4'd9;
    localparam logic [3:0] ERR_EXP      = 4'd10;
    localparam logic [3:0] ERR_LITERAL  = 4'd11;

    localparam logic [1:0] NK_UNSIGNED = 2'd0;
    localparam logic [1:0] NK_SIGNED   = 2'd1;
    localparam logic [1:0] NK_FLOAT    = 2'd2;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [3:0] ev;
        logic [7:0] data;
        logic [1:0] cls;
        logic [3:0] err;
    } result_t;

    // Group of up to four results produced by one input byte.
    typedef struct packed {
        logic [2:0]              count;
        result_t [MAX_RES-1:0]   res;
    } bundle_t;

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'd0;
        case (k)
            2'd0:
            begin
                case (p)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'd0;
                endcase
            end
            2'd1:
            begin
                case (p)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'd0;
                endcase
            end
            2'd2:
            begin
                case (p)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'd0;
                endcase
            end
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        logic [2:0] l;
        case (k)
            2'd0: l = 3'd4;
            2'd1: l = 3'd5;
            2'd2: l = 3'd4;
            default: l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic [30:0] utf8_min(input logic [2:0] len);
        logic [30:0] m;
        case (len)
            3'd2: m = 31'h80;
            3'd3: m = 31'h800;
            3'd4: m = 31'h10000;
            3'd5: m = 31'h200000;
            3'd6: m = 31'h4000000;
            default: m = 31'd0;
        endcase
        return m;
    endfunction

endpackage

// ----- hw/rtl/jts_core.sv -----
`timescale 1ns / 1ps

// Next-state and result logic for one byte; pure combinational.
module jts_core
    import jts_pkg::*;
(
    input  logic [7:0]  in_byte,
    input  logic        at_end,
    input  logic [7:0]  point_char,
    input  scan_mode_t  mode,
    input  logic [1:0]  lit_kind,
    input  logic [2:0]  lit_pos,
    input  logic [2:0]  hex_cnt,
    input  logic [15:0] hex_acc,
    input  logic [15:0] high_sur,
    input  logic [2:0]  u8_rem,
    input  logic [30:0] u8_val,
    input  logic [2:0]  u8_len,
    input  logic [1:0]  num_kind,
    output scan_mode_t  mode_n,
    output logic [1:0]  lit_kind_n,
    output logic [2:0]  lit_pos_n,
    output logic [2:0]  hex_cnt_n,
    output logic [15:0] hex_acc_n,
    output logic [15:0] high_sur_n,
    output logic [2:0]  u8_rem_n,
    output logic [30:0] u8_val_n,
    output logic [2:0]  u8_len_n,
    output logic [1:0]  num_kind_n,
    output bundle_t     bundle
);

    logic        eoi;
    logic [7:0]  b;
    logic        dig;
    logic [4:0]  hv;
    logic [7:0]  lc;
    logic [15:0] acc_new;
    logic [20:0] cp_pair;
    logic [30:0] val_new;
    logic [2:0]  rem_new;

    assign eoi = at_end | (in_byte == 8'd0);
    assign b   = at_end ? 8'd0 : in_byte;
    assign dig = (b >= "0") && (b <= "9");
    assign lc  = b | 8'h20;
    assign acc_new = {hex_acc[11:0], hv[3:0]};
    assign cp_pair = 21'({high_sur[9:0], 10'd0}) + 21'(acc_new[9:0]) + 21'h10000;
    assign val_new = {u8_val[24:0], b[5:0]};
    assign rem_new = u8_rem - 3'd1;

    always_comb
    begin
        if (dig)
            hv = {1'b0, b[3:0] - 4'd0};
        else if (lc >= "a" && lc <= "f")
            hv = {1'b0, lc[3:0] + 4'd9};
        else
            hv = 5'h10;
    end

    // Helpers write into the output bundle in order.
    function automatic bundle_t push(input bundle_t bi, input logic [3:0] ev,
                                     input logic [7:0] d, input logic [1:0] c,
                                     input logic [3:0] e);
        bundle_t bo;
        bo = bi;
        if (bi.count < 3'(MAX_RES))
        begin
            bo.res[bi.count[1:0]] = '{ev: ev, data: d, cls: c, err: e};
            bo.count = bi.count + 3'd1;
        end
        return bo;
    endfunction

    function automatic bundle_t push_cp(input bundle_t bi, input logic [20:0] cp);
        bundle_t bo;
        bo = bi;
        if (cp < 21'h80)
            bo = push(bo, EV_STR_BYTE, cp[7:0], 2'd0, ERR_NONE);
        else if (cp <= 21'h7FF)
        begin
            bo = push(bo, EV_STR_BYTE, {3'b110, cp[10:6]}, 2'd0, ERR_NONE);
            bo = push(bo, EV_STR_BYTE, {2'b10, cp[5:0]}, 2'd0, ERR_NONE);
        end
        else if (cp <= 21'hFFFF)
        begin
            bo = push(bo, EV_STR_BYTE, {4'b1110, cp[15:12]}, 2'd0, ERR_NONE);
            bo = push(bo, EV_STR_BYTE, {2'b10, cp[11:6]}, 2'd0, ERR_NONE);
            bo = push(bo, EV_STR_BYTE, {2'b10, cp[5:0]}, 2'd0, ERR_NONE);
        end
        else
        begin
            bo = push(bo, EV_STR_BYTE, {5'b11110, cp[20:18]}, 2'd0, ERR_NONE);
            bo = push(bo, EV_STR_BYTE, {2'b10, cp[17:12]}, 2'd0, ERR_NONE);
            bo = push(bo, EV_STR_BYTE, {2'b10, cp[11:6]}, 2'd0, ERR_NONE);
            bo = push(bo, EV_STR_BYTE, {2'b10, cp[5:0]}, 2'd0, ERR_NONE);
        end
        return bo;
    endfunction

    always_comb
    begin
        mode_n     = mode;
        lit_kind_n = lit_kind;
        lit_pos_n  = lit_pos;
        hex_cnt_n  = hex_cnt;
        hex_acc_n  = hex_acc;
        high_sur_n = high_sur;
        u8_rem_n   = u8_rem;
        u8_val_n   = u8_val;
        u8_len_n   = u8_len;
        num_kind_n = num_kind;
        bundle     = '0;

        // fail_code != none means an error is raised on this byte.
        begin : body
            logic [3:0] fail_code;
            logic       restart;
            fail_code = ERR_NONE;
            restart   = 1'b0;

            case (mode)
                M_ERROR:
                begin
                    if (eoi)
                    begin
                        bundle = push(bundle, EV_END, 8'd0, 2'd0, ERR_NONE);
                        mode_n = M_START;
                    end
                end
                M_LIT:
                begin
                    if (lit_kind > 2'd2 || lit_pos >= lit_len(lit_kind)
                        || b != lit_char(lit_kind, lit_pos))
                        fail_code = ERR_LITERAL;
                    else
                    begin
                        lit_pos_n = lit_pos + 3'd1;
                        if (lit_pos + 3'd1 == lit_len(lit_kind))
                        begin
                            bundle = push(bundle, EV_TRUE + {2'b00, lit_kind}, 8'd0, 2'd0,
                                          ERR_NONE);
                            mode_n = M_START;
                        end
                    end
                end
                M_STR:
                begin
                    if (eoi)
                        fail_code = ERR_UNCLOSED;
                    else if (b == "\"")
                    begin
                        bundle = push(bundle, EV_STR_END, 8'd0, 2'd0, ERR_NONE);
                        mode_n = M_START;
                    end
                    else if (b == "\\")
                        mode_n = M_ESC;
                    else if (b <= 8'h1F)
                        fail_code = ERR_CONTROL;
                    else if (b < 8'h80)
                        bundle = push(bundle, EV_STR_BYTE, b, 2'd0, ERR_NONE);
                    else
                    begin
                        mode_n = M_UTF8;
                        if (b[7:5] == 3'b110)
                        begin
                            u8_len_n = 3'd2;
                            u8_val_n = 31'(b[4:0]);
                        end
                        else if (b[7:4] == 4'b1110)
                        begin
                            u8_len_n = 3'd3;
                            u8_val_n = 31'(b[3:0]);
                        end
                        else if (b[7:3] == 5'b11110)
                        begin
                            u8_len_n = 3'd4;
                            u8_val_n = 31'(b[2:0]);
                        end
                        else if (b[7:2] == 6'b111110)
                        begin
                            u8_len_n = 3'd5;
                            u8_val_n = 31'(b[1:0]);
                        end
                        else if (b[7:1] == 7'b1111110)
                        begin
                            u8_len_n = 3'd6;
                            u8_val_n = 31'(b[0]);
                        end
                        else
                        begin
                            mode_n   = mode;
                            u8_len_n = u8_len;
                            fail_code = ERR_UTF8;
                        end
                        if (fail_code == ERR_NONE)
                        begin
                            bundle   = push(bundle, EV_STR_BYTE, b, 2'd0, ERR_NONE);
                            u8_rem_n = u8_len_n - 3'd1;
                        end
                    end
                end
                M_ESC:
                begin
                    mode_n = M_STR;
                    case (b)
                        "\"", "\\", "/": bundle = push(bundle, EV_STR_BYTE, b, 2'd0, ERR_NONE);
                        "b": bundle = push(bundle, EV_STR_BYTE, 8'h08, 2'd0, ERR_NONE);
                        "f": bundle = push(bundle, EV_STR_BYTE, 8'h0C, 2'd0, ERR_NONE);
                        "n": bundle = push(bundle, EV_STR_BYTE, 8'h0A, 2'd0, ERR_NONE);
                        "r": bundle = push(bundle, EV_STR_BYTE, 8'h0D, 2'd0, ERR_NONE);
                        "t": bundle = push(bundle, EV_STR_BYTE, 8'h09, 2'd0, ERR_NONE);
                        "u":
                        begin
                            hex_cnt_n = 3'd0;
                            hex_acc_n = 16'd0;
                            mode_n    = M_HEX1;
                        end
                        default: fail_code = ERR_ESCAPE;
                    endcase
                end
                M_HEX1, M_HEX2:
                begin
                    if (hv[4])
                        fail_code = ERR_HEX;
                    else
                    begin
                        hex_acc_n = acc_new;
                        hex_cnt_n = hex_cnt + 3'd1;
                        if (hex_cnt + 3'd1 >= 3'd4)
                        begin
                            if (mode == M_HEX2)
                            begin
                                if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF)
                                begin
                                    bundle = push_cp(bundle, cp_pair);
                                    mode_n = M_STR;
                                end
                                else
                                    fail_code = ERR_NO_LOW;
                            end
                            else if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF)
                            begin
                                high_sur_n = acc_new;
                                mode_n     = M_BSL;
                            end
                            else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF)
                                fail_code = ERR_LONE_LOW;
                            else
                            begin
                                bundle = push_cp(bundle, 21'(acc_new));
                                mode_n = M_STR;
                            end
                        end
                    end
                end
                M_BSL:
                begin
                    if (b == "\\")
                        mode_n = M_U;
                    else
                        fail_code = ERR_NO_LOW;
                end
                M_U:
                begin
                    if (b == "u")
                    begin
                        hex_cnt_n = 3'd0;
                        hex_acc_n = 16'd0;
                        mode_n    = M_HEX2;
                    end
                    else
                        fail_code = ERR_NO_LOW;
                end
                M_UTF8:
                begin
                    if (b[7:6] != 2'b10)
                        fail_code = ERR_UTF8;
                    else
                    begin
                        u8_val_n = val_new;
                        u8_rem_n = rem_new;
                        if (rem_new != 3'd0)
                            bundle = push(bundle, EV_STR_BYTE, b, 2'd0, ERR_NONE);
                        else if (u8_len > 3'd6 || val_new < utf8_min(u8_len))
                            fail_code = ERR_UTF8;
                        else
                        begin
                            bundle = push(bundle, EV_STR_BYTE, b, 2'd0, ERR_NONE);
                            mode_n = M_STR;
                        end
                    end
                end
                M_NMINUS:
                begin
                    if (dig)
                    begin
                        bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                        mode_n = (b == "0") ? M_NZERO : M_NINT;
                    end
                    else
                        fail_code = ERR_MINUS;
                end
                M_NZERO, M_NINT, M_NFRAC:
                begin
                    if (dig && mode != M_NZERO)
                        bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                    else if (b == "." && mode != M_NFRAC)
                    begin
                        num_kind_n = NK_FLOAT;
                        bundle = push(bundle, EV_NUM_BYTE, point_char, 2'd0, ERR_NONE);
                        mode_n = M_NPOINT;
                    end
                    else if (lc == "e")
                    begin
                        num_kind_n = NK_FLOAT;
                        bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                        mode_n = M_NEXP;
                    end
                    else
                    begin
                        bundle  = push(bundle, EV_NUM_END, 8'd0, num_kind, ERR_NONE);
                        restart = 1'b1;
                    end
                end
                M_NPOINT:
                begin
                    if (dig)
                    begin
                        bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                        mode_n = M_NFRAC;
                    end
                    else
                        fail_code = ERR_POINT;
                end
                M_NEXP:
                begin
                    if (b == "+" || b == "-")
                    begin
                        bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                        mode_n = M_NSIGN;
                    end
                    else if (dig)
                    begin
                        bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                        mode_n = M_NEXPD;
                    end
                    else
                        fail_code = ERR_EXP;
                end
                M_NSIGN:
                begin
                    if (dig)
                    begin
                        bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                        mode_n = M_NEXPD;
                    end
                    else
                        fail_code = ERR_EXP;
                end
                M_NEXPD:
                begin
                    if (dig)
                        bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                    else
                    begin
                        bundle  = push(bundle, EV_NUM_END, 8'd0, num_kind, ERR_NONE);
                        restart = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase

            // Token start: also the rescan of the byte that ended a number.
            if (restart)
            begin
                mode_n = M_START;
                if (eoi)
                    bundle = push(bundle, EV_END, 8'd0, 2'd0, ERR_NONE);
                else
                begin
                    case (b)
                        " ", 8'h09, 8'h0A, 8'h0D: mode_n = M_START;
                        "[": bundle = push(bundle, EV_LBRACK, 8'd0, 2'd0, ERR_NONE);
                        "]": bundle = push(bundle, EV_RBRACK, 8'd0, 2'd0, ERR_NONE);
                        "{": bundle = push(bundle, EV_LBRACE, 8'd0, 2'd0, ERR_NONE);
                        "}": bundle = push(bundle, EV_RBRACE, 8'd0, 2'd0, ERR_NONE);
                        ":": bundle = push(bundle, EV_COLON, 8'd0, 2'd0, ERR_NONE);
                        ",": bundle = push(bundle, EV_COMMA, 8'd0, 2'd0, ERR_NONE);
                        "\"": mode_n = M_STR;
                        "t", "f", "n":
                        begin
                            lit_kind_n = (b == "t") ? 2'd0 : ((b == "f") ? 2'd1 : 2'd2);
                            lit_pos_n  = 3'd1;
                            mode_n     = M_LIT;
                        end
                        "-":
                        begin
                            num_kind_n = NK_SIGNED;
                            bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                            mode_n = M_NMINUS;
                        end
                        default:
                        begin
                            if (dig)
                            begin
                                num_kind_n = NK_UNSIGNED;
                                bundle = push(bundle, EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                                mode_n = (b == "0") ? M_NZERO : M_NINT;
                            end
                            else
                            begin
                                bundle = push(bundle, EV_ERROR, 8'd0, 2'd0, ERR_LITERAL);
                                mode_n = M_ERROR;
                            end
                        end
                    endcase
                end
            end

            if (fail_code != ERR_NONE)
            begin
                bundle = push(bundle, EV_ERROR, 8'd0, 2'd0, fail_code);
                if (eoi)
                begin
                    bundle = push(bundle, EV_END, 8'd0, 2'd0, ERR_NONE);
                    mode_n = M_START;
                end
                else
                    mode_n = M_ERROR;
            end
        end
    end

endmodule

// ----- hw/rtl/jts_outq.sv -----
`timescale 1ns / 1ps

// Result register: holds one bundle and hands its results out one per transfer.
module jts_outq
    import jts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  bundle_t    bundle_in,
    output logic       busy,
    output logic       free_next,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] event_res,
    output logic [7:0] data_byte,
    output logic [1:0] number_class,
    output logic [3:0] error_code,
    output logic       last
);

    bundle_t    bun_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic       take;
    logic       final_one;

    assign take      = valid_reg && !out_stall;
    assign final_one = (idx_reg + 3'd1 == bun_reg.count);
    assign free_next = !valid_reg || (take && final_one);
    assign busy      = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (take)
        begin
            idx_next = idx_reg + 3'd1;
            if (final_one)
                valid_next = 1'b0;
        end
        if (load && bundle_in.count != 3'd0)
        begin
            valid_next = 1'b1;
            idx_next   = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bun_reg <= bundle_in;
    end

    assign out_valid    = valid_reg;
    assign event_res    = bun_reg.res[idx_reg[1:0]].ev;
    assign data_byte    = bun_reg.res[idx_reg[1:0]].data;
    assign number_class = bun_reg.res[idx_reg[1:0]].cls;
    assign error_code   = bun_reg.res[idx_reg[1:0]].err;
    assign last         = final_one;

`ifndef SYNTH
    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (bun_reg.count != 3'd0 && idx_reg < bun_reg.count))
        else $error("result index out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |=> (valid_reg && $stable(idx_reg)))
        else $error("stalled result moved");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free_next)
        else $error("bundle loaded over pending results");
`endif

endmodule

// ----- hw/rtl/json_token_scanner.sv -----
`timescale 1ns / 1ps

// JSON token scanner. Each input transfer carries one byte (or an end mark) and
// yields zero to four result transfers: string bytes, number text bytes, number
// end with its class, structural tokens, literals, end of input or an error.
// The byte is registered at the input, the whole scanner step is short logic
// from that register, and its results are held in a result register that
// hands them out one per cycle unless the output stalls. Ordinary text, whose
// bytes make no result or a single result, runs at one byte per clock while the
// output does not stall; a byte with more results stalls the input until all
// are taken. The decimal point register may only be written while idle.
module json_token_scanner
    import jts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       at_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] event_res,
    output logic [7:0] data_byte,
    output logic [1:0] number_class,
    output logic [3:0] error_code,
    output logic       last
);

    logic [7:0]  dp_reg;
    logic        iv_reg;
    logic [7:0]  ib_reg;
    logic        ie_reg;
    scan_mode_t  mode_reg, mode_next;
    logic [1:0]  lk_reg, lk_next;
    logic [2:0]  lp_reg, lp_next;
    logic [2:0]  hc_reg, hc_next;
    logic [15:0] ha_reg, ha_next;
    logic [15:0] hs_reg, hs_next;
    logic [2:0]  ur_reg, ur_next;
    logic [30:0] uv_reg, uv_next;
    logic [2:0]  ul_reg, ul_next;
    logic [1:0]  nk_reg, nk_next;
    bundle_t     bundle;
    logic        q_busy;
    logic        q_free;
    logic        step;

    // The held byte is processed when the result register can take its bundle.
    assign step      = iv_reg && q_free;
    assign in_stall  = iv_reg && !q_free;
    assign cfg_ready = 1'b1;

    jts_core u_core (
        .in_byte(ib_reg), .at_end(ie_reg), .point_char(dp_reg),
        .mode(mode_reg), .lit_kind(lk_reg), .lit_pos(lp_reg),
        .hex_cnt(hc_reg), .hex_acc(ha_reg), .high_sur(hs_reg),
        .u8_rem(ur_reg), .u8_val(uv_reg), .u8_len(ul_reg), .num_kind(nk_reg),
        .mode_n(mode_next), .lit_kind_n(lk_next), .lit_pos_n(lp_next),
        .hex_cnt_n(hc_next), .hex_acc_n(ha_next), .high_sur_n(hs_next),
        .u8_rem_n(ur_next), .u8_val_n(uv_next), .u8_len_n(ul_next),
        .num_kind_n(nk_next), .bundle(bundle)
    );

    jts_outq u_outq (
        .clk(clk), .rst_n(rst_n), .load(step), .bundle_in(bundle),
        .busy(q_busy), .free_next(q_free),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .data_byte(data_byte), .number_class(number_class),
        .error_code(error_code), .last(last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg   <= 8'd46;
            iv_reg   <= 1'b0;
            mode_reg <= M_START;
            lk_reg   <= 2'd0;
            lp_reg   <= 3'd0;
            hc_reg   <= 3'd0;
            ha_reg   <= 16'd0;
            hs_reg   <= 16'd0;
            ur_reg   <= 3'd0;
            uv_reg   <= 31'd0;
            ul_reg   <= 3'd0;
            nk_reg   <= NK_UNSIGNED;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                dp_reg <= cfg_data;
            if (in_valid && !in_stall)
                iv_reg <= 1'b1;
            else if (step)
                iv_reg <= 1'b0;
            if (step)
            begin
                mode_reg <= mode_next;
                lk_reg   <= lk_next;
                lp_reg   <= lp_next;
                hc_reg   <= hc_next;
                ha_reg   <= ha_next;
                hs_reg   <= hs_next;
                ur_reg   <= ur_next;
                uv_reg   <= uv_next;
                ul_reg   <= ul_next;
                nk_reg   <= nk_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ib_reg <= in_byte;
            ie_reg <= at_end;
        end
    end

`ifndef SYNTH
    a_no_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && q_busy) |-> (!out_stall && last))
        else $error("byte stepped while results pending");
    a_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_ERROR && last) |-> (mode_reg == M_ERROR))
        else $error("error not followed by error mode");
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> iv_reg)
        else $error("stalled input byte lost");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the JSON token scanner. A queue of pending input
// bytes is filled by the stimulus process and fed to the block by a clocked
// driver. At every accepted input transfer, the driver runs a software copy
// of the scanner, which appends the results that the byte should cause to the
// queue of expected tokens. A clocked monitor compares every accepted result
// transfer with the oldest entry of that queue. Both sides insert random gaps,
// with calm stretches where neither side idles.
module tb
    import jts_pkg::*;
;

    typedef struct {
        logic [7:0] b;
        logic       e;
    } byte_item_t;

    typedef struct {
        logic [3:0] ev;
        logic [7:0] data;
        logic [1:0] cls;
        logic [3:0] err;
        logic       last;
    } token_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'd0;
    logic       at_end = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] event_res;
    logic [7:0] data_byte;
    logic [1:0] number_class;
    logic [3:0] error_code;
    logic       last;

    json_token_scanner u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .at_end       (at_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .data_byte    (data_byte),
        .number_class (number_class),
        .error_code   (error_code),
        .last         (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Bytes waiting to be sent, and tokens the scanner still owes us.
    byte_item_t pending_bytes[$];
    token_t     expected_tokens[$];
    token_t     step_tokens[$];
    int         mismatches = 0;
    bit         hold_input = 1'b0;
    bit         calm = 1'b0;

    // Software copy of the scanner state and of the decimal point register.
    logic [7:0]  dp_shadow = 8'd46;
    scan_mode_t  mode = M_START;
    logic [1:0]  lit_kind = 2'd0;
    logic [2:0]  lit_pos = 3'd0;
    logic [2:0]  hex_cnt = 3'd0;
    logic [15:0] hex_acc = 16'd0;
    logic [15:0] hi_surr = 16'd0;
    logic [2:0]  u8_left = 3'd0;
    logic [30:0] u8_val = 31'd0;
    logic [2:0]  u8_len = 3'd0;
    logic [1:0]  num_kind = NK_UNSIGNED;

    string lit_words[3] = '{"true", "false", "null"};

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    task automatic emit(logic [3:0] ev, logic [7:0] data, logic [1:0] cls, logic [3:0] err);
        token_t t;
        t.ev = ev;
        t.data = data;
        t.cls = cls;
        t.err = err;
        t.last = 1'b0;
        if (step_tokens.size() < MAX_RES)
            step_tokens.insert(step_tokens.size(), t);
    endtask

    // An error on an end item also closes the input; otherwise the scanner
    // drops bytes until the next end item.
    task automatic raise(logic [3:0] code, bit fin);
        emit(EV_ERROR, 8'd0, 2'd0, code);
        if (fin)
        begin
            emit(EV_END, 8'd0, 2'd0, ERR_NONE);
            mode = M_START;
        end
        else
            mode = M_ERROR;
    endtask

    task automatic emit_utf8(int unsigned cp);
        if (cp < 32'h80)
            emit(EV_STR_BYTE, cp[7:0], 2'd0, ERR_NONE);
        else if (cp <= 32'h7FF)
        begin
            emit(EV_STR_BYTE, 8'hC0 | cp[10:6], 2'd0, ERR_NONE);
            emit(EV_STR_BYTE, 8'h80 | cp[5:0], 2'd0, ERR_NONE);
        end
        else if (cp <= 32'hFFFF)
        begin
            emit(EV_STR_BYTE, 8'hE0 | cp[15:12], 2'd0, ERR_NONE);
            emit(EV_STR_BYTE, 8'h80 | cp[11:6], 2'd0, ERR_NONE);
            emit(EV_STR_BYTE, 8'h80 | cp[5:0], 2'd0, ERR_NONE);
        end
        else
        begin
            emit(EV_STR_BYTE, 8'hF0 | cp[20:18], 2'd0, ERR_NONE);
            emit(EV_STR_BYTE, 8'h80 | cp[17:12], 2'd0, ERR_NONE);
            emit(EV_STR_BYTE, 8'h80 | cp[11:6], 2'd0, ERR_NONE);
            emit(EV_STR_BYTE, 8'h80 | cp[5:0], 2'd0, ERR_NONE);
        end
    endtask

    task automatic at_token_start(logic [7:0] b, bit fin);
        mode = M_START;
        if (fin)
        begin
            emit(EV_END, 8'd0, 2'd0, ERR_NONE);
            return;
        end
        case (b)
            " ", "\t", "\n", "\r": ;
            "[": emit(EV_LBRACK, 8'd0, 2'd0, ERR_NONE);
            "]": emit(EV_RBRACK, 8'd0, 2'd0, ERR_NONE);
            "{": emit(EV_LBRACE, 8'd0, 2'd0, ERR_NONE);
            "}": emit(EV_RBRACE, 8'd0, 2'd0, ERR_NONE);
            ":": emit(EV_COLON, 8'd0, 2'd0, ERR_NONE);
            ",": emit(EV_COMMA, 8'd0, 2'd0, ERR_NONE);
            "\"": mode = M_STR;
            "t", "f", "n":
            begin
                lit_kind = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
                lit_pos = 3'd1;
                mode = M_LIT;
            end
            "-":
            begin
                num_kind = NK_SIGNED;
                emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                mode = M_NMINUS;
            end
            default:
            begin
                if (is_dig(b))
                begin
                    num_kind = NK_UNSIGNED;
                    emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                    mode = (b == "0") ? M_NZERO : M_NINT;
                end
                else
                    raise(ERR_LITERAL, 1'b0);
            end
        endcase
    endtask

    task automatic close_number(logic [7:0] b, bit fin);
        emit(EV_NUM_END, 8'd0, num_kind, ERR_NONE);
        at_token_start(b, fin);
    endtask

    task automatic take_hex(logic [7:0] b, bit fin, bit low_half);
        logic [7:0] lc;
        int         v;
        int unsigned cp;
        lc = b | 8'h20;
        if (is_dig(b))
            v = b - "0";
        else if (lc >= "a" && lc <= "f")
            v = 10 + lc - "a";
        else
        begin
            raise(ERR_HEX, fin);
            return;
        end
        hex_acc = {hex_acc[11:0], v[3:0]};
        hex_cnt = hex_cnt + 3'd1;
        if (hex_cnt < 3'd4)
            return;
        cp = 32'(hex_acc);
        if (low_half)
        begin
            if (cp >= 32'hDC00 && cp <= 32'hDFFF)
            begin
                emit_utf8((int'(hi_surr) << 10) + cp - 32'h35FDC00);
                mode = M_STR;
            end
            else
                raise(ERR_NO_LOW, fin);
        end
        else if (cp >= 32'hD800 && cp <= 32'hDBFF)
        begin
            hi_surr = hex_acc;
            mode = M_BSL;
        end
        else if (cp >= 32'hDC00 && cp <= 32'hDFFF)
            raise(ERR_LONE_LOW, fin);
        else
        begin
            emit_utf8(cp);
            mode = M_STR;
        end
    endtask

    task automatic in_string(logic [7:0] b, bit fin);
        if (fin)
            raise(ERR_UNCLOSED, 1'b1);
        else if (b == "\"")
        begin
            emit(EV_STR_END, 8'd0, 2'd0, ERR_NONE);
            mode = M_START;
        end
        else if (b == "\\")
            mode = M_ESC;
        else if (b <= 8'h1F)
            raise(ERR_CONTROL, 1'b0);
        else if (b < 8'h80)
            emit(EV_STR_BYTE, b, 2'd0, ERR_NONE);
        else
        begin
            if (b[7:5] == 3'b110)
            begin
                u8_len = 3'd2;
                u8_val = 31'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110)
            begin
                u8_len = 3'd3;
                u8_val = 31'(b[3:0]);
            end
            else if (b[7:3] == 5'b11110)
            begin
                u8_len = 3'd4;
                u8_val = 31'(b[2:0]);
            end
            else if (b[7:2] == 6'b111110)
            begin
                u8_len = 3'd5;
                u8_val = 31'(b[1:0]);
            end
            else if (b[7:1] == 7'b1111110)
            begin
                u8_len = 3'd6;
                u8_val = 31'(b[0]);
            end
            else
            begin
                raise(ERR_UTF8, 1'b0);
                return;
            end
            emit(EV_STR_BYTE, b, 2'd0, ERR_NONE);
            u8_left = u8_len - 3'd1;
            mode = M_UTF8;
        end
    endtask

    task automatic in_utf8(logic [7:0] b, bit fin);
        logic [30:0] floor_val;
        if (b[7:6] != 2'b10)
        begin
            raise(ERR_UTF8, fin);
            return;
        end
        u8_val = {u8_val[24:0], b[5:0]};
        u8_left = u8_left - 3'd1;
        if (u8_left != 3'd0)
        begin
            emit(EV_STR_BYTE, b, 2'd0, ERR_NONE);
            return;
        end
        case (u8_len)
            3'd2: floor_val = 31'h80;
            3'd3: floor_val = 31'h800;
            3'd4: floor_val = 31'h10000;
            3'd5: floor_val = 31'h200000;
            default: floor_val = 31'h4000000;
        endcase
        // Overlong forms fail on their final byte.
        if (u8_val < floor_val)
        begin
            raise(ERR_UTF8, fin);
            return;
        end
        emit(EV_STR_BYTE, b, 2'd0, ERR_NONE);
        mode = M_STR;
    endtask

    task automatic in_escape(logic [7:0] b, bit fin);
        mode = M_STR;
        case (b)
            "\"", "\\", "/": emit(EV_STR_BYTE, b, 2'd0, ERR_NONE);
            "b": emit(EV_STR_BYTE, 8'h08, 2'd0, ERR_NONE);
            "f": emit(EV_STR_BYTE, 8'h0C, 2'd0, ERR_NONE);
            "n": emit(EV_STR_BYTE, 8'h0A, 2'd0, ERR_NONE);
            "r": emit(EV_STR_BYTE, 8'h0D, 2'd0, ERR_NONE);
            "t": emit(EV_STR_BYTE, 8'h09, 2'd0, ERR_NONE);
            "u":
            begin
                hex_cnt = 3'd0;
                hex_acc = 16'd0;
                mode = M_HEX1;
            end
            default: raise(ERR_ESCAPE, fin);
        endcase
    endtask

    task automatic in_literal(logic [7:0] b, bit fin);
        string w;
        w = lit_words[lit_kind];
        if (lit_pos >= w.len() || b != w[lit_pos])
        begin
            raise(ERR_LITERAL, fin);
            return;
        end
        lit_pos = lit_pos + 3'd1;
        if (lit_pos == w.len())
        begin
            emit(EV_TRUE + lit_kind, 8'd0, 2'd0, ERR_NONE);
            mode = M_START;
        end
    endtask

    // One scanner step: appends the tokens caused by one input byte.
    task automatic scan_step(logic [7:0] raw, logic end_flag);
        logic [7:0] b;
        bit         fin;
        token_t     t;
        fin = end_flag;
        b = fin ? 8'd0 : raw;
        if (b == 8'd0)
            fin = 1'b1;
        step_tokens.delete();
        case (mode)
            M_ERROR:
            begin
                if (fin)
                begin
                    emit(EV_END, 8'd0, 2'd0, ERR_NONE);
                    mode = M_START;
                end
            end
            M_LIT: in_literal(b, fin);
            M_STR: in_string(b, fin);
            M_ESC: in_escape(b, fin);
            M_HEX1: take_hex(b, fin, 1'b0);
            M_HEX2: take_hex(b, fin, 1'b1);
            M_BSL:
            begin
                if (b == "\\")
                    mode = M_U;
                else
                    raise(ERR_NO_LOW, fin);
            end
            M_U:
            begin
                if (b == "u")
                begin
                    hex_cnt = 3'd0;
                    hex_acc = 16'd0;
                    mode = M_HEX2;
                end
                else
                    raise(ERR_NO_LOW, fin);
            end
            M_UTF8: in_utf8(b, fin);
            M_NMINUS:
            begin
                if (is_dig(b))
                begin
                    emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                    mode = (b == "0") ? M_NZERO : M_NINT;
                end
                else
                    raise(ERR_MINUS, fin);
            end
            M_NZERO, M_NINT, M_NFRAC:
            begin
                // A digit after a leading zero closes the number and is rescanned.
                if (is_dig(b) && mode != M_NZERO)
                    emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                else if (b == "." && mode != M_NFRAC)
                begin
                    num_kind = NK_FLOAT;
                    emit(EV_NUM_BYTE, dp_shadow, 2'd0, ERR_NONE);
                    mode = M_NPOINT;
                end
                else if ((b | 8'h20) == "e")
                begin
                    num_kind = NK_FLOAT;
                    emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                    mode = M_NEXP;
                end
                else
                    close_number(b, fin);
            end
            M_NPOINT:
            begin
                if (is_dig(b))
                begin
                    emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                    mode = M_NFRAC;
                end
                else
                    raise(ERR_POINT, fin);
            end
            M_NEXP:
            begin
                if (b == "+" || b == "-")
                begin
                    emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                    mode = M_NSIGN;
                end
                else if (is_dig(b))
                begin
                    emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                    mode = M_NEXPD;
                end
                else
                    raise(ERR_EXP, fin);
            end
            M_NSIGN:
            begin
                if (is_dig(b))
                begin
                    emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                    mode = M_NEXPD;
                end
                else
                    raise(ERR_EXP, fin);
            end
            M_NEXPD:
            begin
                if (is_dig(b))
                    emit(EV_NUM_BYTE, b, 2'd0, ERR_NONE);
                else
                    close_number(b, fin);
            end
            default: at_token_start(b, fin);
        endcase
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i])
        begin
            t = step_tokens[i];
            expected_tokens.insert(expected_tokens.size(), t);
        end
    endtask

    // Driver: the byte is predicted at the edge where its transfer completes,
    // then the next byte is loaded after an optional gap. Each output gets one
    // nonblocking assignment per edge.
    logic [7:0] next_byte;
    logic       next_end;
    logic       next_valid;
    int         gap_left = 0;
    int         gap_roll;
    byte_item_t loaded;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            next_valid = in_valid;
            next_byte = in_byte;
            next_end = at_end;
            if (in_valid && !in_stall)
            begin
                scan_step(in_byte, at_end);
                next_valid = 1'b0;
                gap_roll = $urandom_range(0, 99);
                if (calm || gap_roll < 60)
                    gap_left = 0;
                else if (gap_roll < 93)
                    gap_left = $urandom_range(1, 3);
                else
                    gap_left = $urandom_range(8, 30);
                if ($urandom_range(0, 39) == 0)
                    calm <= !calm;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                else if (!hold_input && pending_bytes.size() > 0)
                begin
                    loaded = pending_bytes.pop_front();
                    next_valid = 1'b1;
                    next_byte = loaded.b;
                    next_end = loaded.e;
                end
            end
            in_valid <= next_valid;
            in_byte <= next_byte;
            at_end <= next_end;
        end
    end

    // Monitor: checks each result transfer and draws the next stall.
    token_t want;
    int     stall_left = 0;
    int     stall_roll;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: unexpected result ev=%0d data=%02h cls=%0d err=%0d last=%0b",
                                 event_res, data_byte, number_class, error_code, last);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (event_res !== want.ev || data_byte !== want.data
                        || number_class !== want.cls || error_code !== want.err
                        || last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"tb: mismatch at %0t: expected ev=%0d data=%02h cls=%0d ",
                                      "err=%0d last=%0b, got ev=%0d data=%02h cls=%0d err=%0d ",
                                      "last=%0b"}, $time, want.ev, want.data, want.cls,
                                     want.err, want.last, event_res, data_byte, number_class,
                                     error_code, last);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_roll = $urandom_range(0, 99);
                if (calm || stall_roll >= 25)
                    out_stall <= 1'b0;
                else
                begin
                    stall_left = (stall_roll < 3) ? $urandom_range(8, 30) : $urandom_range(0, 2);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // Stimulus helpers.
    task automatic put_byte(logic [7:0] b);
        byte_item_t it;
        it.b = b;
        it.e = 1'b0;
        pending_bytes.insert(pending_bytes.size(), it);
    endtask

    task automatic put_text(string s);
        foreach (s[i])
            put_byte(s[i]);
    endtask

    // End of input, either by the flag (with a random byte) or by a zero byte.
    task automatic put_end();
        byte_item_t it;
        if ($urandom_range(0, 2) == 0)
        begin
            it.b = 8'd0;
            it.e = 1'b0;
        end
        else
        begin
            it.b = 8'($urandom_range(0, 255));
            it.e = 1'b1;
        end
        pending_bytes.insert(pending_bytes.size(), it);
    endtask

    task automatic put_digits(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n)
            put_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic put_hex4();
        string hx;
        hx = "0123456789abcdefABCDEF";
        repeat (4)
            put_byte(hx[$urandom_range(0, 21)]);
    endtask

    task automatic put_hex4_tail();
        string hx;
        hx = "0123456789abcdefABCDEF";
        repeat (2)
            put_byte(hx[$urandom_range(0, 21)]);
    endtask

    // Raw UTF-8 of the given length; overlong values are allowed on purpose.
    task automatic put_raw_utf8(int len, int unsigned v);
        logic [7:0] lead_mark;
        case (len)
            2: lead_mark = 8'hC0;
            3: lead_mark = 8'hE0;
            4: lead_mark = 8'hF0;
            5: lead_mark = 8'hF8;
            default: lead_mark = 8'hFC;
        endcase
        put_byte(lead_mark | 8'(v >> (6 * (len - 1))));
        for (int k = len - 2; k >= 0; k--)
            put_byte(8'(32'h80 | ((v >> (6 * k)) & 32'h3F)));
    endtask

    task automatic put_string_body();
        int n;
        int pick;
        int len;
        int unsigned v;
        string esc;
        string hi_digits;
        esc = "\"\\/bfnrt";
        hi_digits = "89ab";
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                v = $urandom_range(32, 126);
                if (v == "\"" || v == "\\")
                    v = "a";
                put_byte(8'(v));
            end
            else if (pick < 60)
            begin
                put_byte("\\");
                put_byte(esc[$urandom_range(0, 7)]);
            end
            else if (pick < 72)
            begin
                put_text("\\u");
                put_hex4();
            end
            else if (pick < 80)
            begin
                put_text("\\u");
                put_byte("d");
                put_byte(hi_digits[$urandom_range(0, 3)]);
                put_byte(8'("0" + $urandom_range(0, 9)));
                put_byte(8'("a" + $urandom_range(0, 5)));
                put_text("\\u");
                put_byte("D");
                put_byte(8'("c" + $urandom_range(0, 3)));
                put_hex4_tail();
            end
            else
            begin
                len = (pick < 95) ? $urandom_range(2, 4) : $urandom_range(5, 6);
                case (len)
                    2: v = $urandom_range(32'h80, 32'h7FF);
                    3: v = $urandom_range(32'h800, 32'hFFFF);
                    4: v = $urandom_range(32'h10000, 32'h1FFFFF);
                    5: v = $urandom_range(32'h200000, 32'h3FFFFFF);
                    default: v = $urandom_range(32'h4000000, 32'h7FFFFFFF);
                endcase
                if ($urandom_range(0, 9) == 0)
                    v = $urandom_range(0, 32'h7F);
                put_raw_utf8(len, v);
            end
        end
    endtask

    task automatic put_number();
        if ($urandom_range(0, 2) == 0)
            put_byte("-");
        if ($urandom_range(0, 4) == 0)
            put_byte("0");
        else
        begin
            put_byte(8'("1" + $urandom_range(0, 8)));
            put_digits(0, 3);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            put_byte(".");
            put_digits(1, 3);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            put_byte($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0: put_byte("+");
                1: put_byte("-");
                default: ;
            endcase
            put_digits(1, 2);
        end
    endtask

    // One random token, mostly well formed; the rest is noise and broken text.
    task automatic put_token();
        int pick;
        string punct;
        string ws;
        punct = "[]{}:,";
        ws = " \t\n\r";
        pick = $urandom_range(0, 99);
        if (pick < 18)
            put_byte(punct[$urandom_range(0, 5)]);
        else if (pick < 28)
            put_text(lit_words[$urandom_range(0, 2)]);
        else if (pick < 48)
            put_number();
        else if (pick < 72)
        begin
            put_byte("\"");
            put_string_body();
            if ($urandom_range(0, 9) != 0)
                put_byte("\"");
        end
        else if (pick < 80)
            put_byte(ws[$urandom_range(0, 3)]);
        else if (pick < 88)
            put_byte(8'($urandom_range(1, 255)));
        else if (pick < 92)
        begin
            put_text(lit_words[$urandom_range(0, 2)].substr(0, $urandom_range(0, 2)));
            put_byte(8'($urandom_range(1, 255)));
        end
        else
            put_end();
        // Keep numbers apart from what follows about one time in three.
        if ($urandom_range(0, 2) == 0)
            put_byte(" ");
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() > 0 || in_valid || expected_tokens.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_decimal_point(logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        dp_shadow = v;
        cfg_valid <= 1'b0;
    endtask

    logic [7:0] dp_settings[4];
    int         half_mark;

    initial
    begin
        dp_settings[0] = 8'd46;
        dp_settings[1] = 8'd0;
        dp_settings[2] = 8'd255;
        dp_settings[3] = 8'($urandom_range(1, 254));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: structure, literals, numbers, escapes and errors.
        put_text("[]{}:, \t\n\rtrue false null");
        put_text("-0.5e+12,0 07 12E3 -x");
        put_end();
        put_text("1.e");
        put_end();
        put_text("\"a\\n\\u00e9\\ud83d\\ude00\\\"\"");
        put_byte("\"");
        put_raw_utf8(2, 32'hE9);
        put_raw_utf8(2, 32'h01);
        put_end();
        put_text("\"\\udc00");
        put_end();
        put_text("\"x");
        put_byte(8'h01);
        put_text("ignored");
        put_end();
        put_text("\"");
        put_byte(8'hFF);
        put_end();
        put_text("trux");
        put_end();
        put_text("\"\\q");
        put_end();
        put_text("\"\\u12g");
        put_end();
        put_text("\"\\ud800x");
        put_end();
        put_text("-");
        put_end();
        put_text("\"open");
        put_end();
        wait_idle();

        foreach (dp_settings[p])
        begin
            write_decimal_point(dp_settings[p]);
            while (pending_bytes.size() < 25)
                put_token();
            put_text("3.25 ");
            put_end();
            // Once in the run the sender holds off until the scanner has drained.
            if (p == 1)
            begin
                half_mark = pending_bytes.size() / 2;
                while (pending_bytes.size() > half_mark)
                    @(posedge clk);
                hold_input = 1'b1;
                while (in_valid || expected_tokens.size() > 0)
                    @(posedge clk);
                hold_input = 1'b0;
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
